FILE: design/imuc_pkg.sv
// Shared types, constants and helpers for the IMU scale/filter/attitude block.
// No dependencies; every other design file imports this package.
package imuc_pkg;

    localparam int GYRO_SCALE_Q16 = 2;
    localparam int SAMPLE_RATE_HZ = 1000;
    localparam int ONE_Q15        = 32768;
    localparam int HALF_PI_Q16    = 102944;
    localparam int CORDIC_STEPS   = 17;
    localparam int DIV_BITS       = 33;
    localparam int CORDIC_W       = 53;
    localparam int ANGLE_W        = 20;

    // rate term by reciprocal multiply; exact for |rate| below 2^18
    localparam int RATE_SHIFT     = 28;
    localparam int RATE_RECIP     = int'(((64'sd1 <<< RATE_SHIFT) + 64'(SAMPLE_RATE_HZ)
                                          - 64'sd1) / 64'(SAMPLE_RATE_HZ));

    localparam logic [2:0] CFG_GYRO_BIAS     = 3'd0;
    localparam logic [2:0] CFG_ACCEL_BIAS    = 3'd1;
    localparam logic [2:0] CFG_ACCEL_RANGE   = 3'd2;
    localparam logic [2:0] CFG_MAG_BIAS      = 3'd3;
    localparam logic [2:0] CFG_MAG_RANGE     = 3'd4;
    localparam logic [2:0] CFG_LOWPASS_GAINS = 3'd5;
    localparam logic [2:0] CFG_BLEND_GAIN    = 3'd6;
    localparam logic [2:0] CFG_MAG_DECIM     = 3'd7;

    // job and lane numbering used between controller and datapath
    localparam logic [3:0] LANE_AXIS_LAST    = 4'd2;
    localparam logic [3:0] LANE_ANGLE_LAST   = 4'd1;
    localparam logic [3:0] DJ_ACC_X          = 4'd0;
    localparam logic [3:0] DJ_ACC_Y          = 4'd1;
    localparam logic [3:0] DJ_ACC_Z          = 4'd2;
    localparam logic [3:0] DJ_MAG_X          = 4'd3;
    localparam logic [3:0] DJ_MAG_Y          = 4'd4;
    localparam logic [3:0] DJ_MAG_Z          = 4'd5;
    localparam logic [3:0] LPF_ACCEL_LAST    = 4'd5;
    localparam logic [3:0] LPF_LAST          = 4'd8;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] gyro_filt_x;
        logic signed [31:0] gyro_filt_y;
        logic signed [31:0] gyro_filt_z;
        logic signed [31:0] accel_filt_x;
        logic signed [31:0] accel_filt_y;
        logic signed [31:0] accel_filt_z;
        logic signed [31:0] mag_filt_x;
        logic signed [31:0] mag_filt_y;
        logic signed [31:0] mag_filt_z;
        logic               mag_updated;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GYRO_MUL,
        S_GYRO_WB,
        S_DIV_START,
        S_DIV_WAIT,
        S_LPF_MUL,
        S_LPF_WB,
        S_CORDIC_START,
        S_CORDIC_WAIT,
        S_BLEND_G,
        S_BLEND_A,
        S_BLEND_WB,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_GYRO,
        MUL_LPF,
        MUL_BLEND_G,
        MUL_BLEND_A
    } mul_sel_t;

    typedef struct packed {
        logic       capture;
        logic       gyro_wb;
        logic       lpf_wb;
        logic       acc_load;
        logic       blend_wb;
        logic       div_start;
        logic       cordic_start;
        logic       out_load;
        mul_sel_t   mul_sel;
        logic [3:0] lane;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic get_mag;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // round to nearest, ties toward plus infinity, then drop 15 fraction bits
    function automatic logic signed [63:0] r15(input logic signed [63:0] v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] cordic_atan(input logic [4:0] i);
        logic signed [ANGLE_W-1:0] t;
        unique case (i)
            5'd0:    t = 20'sd51472;
            5'd1:    t = 20'sd30386;
            5'd2:    t = 20'sd16055;
            5'd3:    t = 20'sd8150;
            5'd4:    t = 20'sd4091;
            5'd5:    t = 20'sd2047;
            5'd6:    t = 20'sd1024;
            5'd7:    t = 20'sd512;
            5'd8:    t = 20'sd256;
            5'd9:    t = 20'sd128;
            5'd10:   t = 20'sd64;
            5'd11:   t = 20'sd32;
            5'd12:   t = 20'sd16;
            5'd13:   t = 20'sd8;
            5'd14:   t = 20'sd4;
            5'd15:   t = 20'sd2;
            5'd16:   t = 20'sd1;
            default: t = 20'sd0;
        endcase
        return t;
    endfunction

endpackage

FILE: design/imuc_div.sv
// Bit-serial signed divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on imuc_pkg.
module imuc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [33:0]  num,
    input  logic [15:0]         den,
    output logic                done,
    output logic signed [31:0]  quot
);
    import imuc_pkg::*;

    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [15:0]         rem_reg, rem_next;
    logic [15:0]         den_reg;
    logic [5:0]          cnt_reg;
    logic                busy_reg, done_reg;
    logic                neg_reg, nz_reg;
    logic [16:0]         rem_sh;
    logic                ge;
    logic [33:0]         mag;

    assign mag      = num[33] ? 34'(-num) : 34'(num);
    assign rem_sh   = {rem_reg, quo_reg[DIV_BITS-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? 16'(rem_sh - {1'b0, den_reg}) : rem_sh[15:0];
    assign quo_next = {quo_reg[DIV_BITS-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag[DIV_BITS-1:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[33];
            nz_reg  <= |num;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        if (den_reg == 16'd0)
            quot = !nz_reg ? 32'sd0 : (neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF);
        else if (!neg_reg)
            quot = (quo_reg > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : quo_reg[31:0];
        else
            quot = (quo_reg > 33'h080000000) ? 32'sh80000000 : 32'(-quo_reg);
    end

    assign done = done_reg;

endmodule

FILE: design/imuc_cordic.sv
// Iterative CORDIC vectoring unit for atan2, one rotation per cycle.
// Depends on imuc_pkg.
module imuc_cordic (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [32:0]         y_in,
    input  logic signed [32:0]         x_in,
    output logic                       done,
    output logic signed [imuc_pkg::ANGLE_W-1:0] angle
);
    import imuc_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg, y_reg, xs, ys, xw, yw;
    logic signed [ANGLE_W-1:0]  z_reg;
    logic [4:0]                 i_reg;
    logic                       busy_reg, done_reg, zero_reg;

    assign xw = {{4{x_in[32]}}, x_in, 16'b0};
    assign yw = {{4{y_in[32]}}, y_in, 16'b0};
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg    <= '0;
            zero_reg <= (x_in == 33'sd0) && (y_in == 33'sd0);
            if (xw < 0 && yw >= 0)
            begin
                x_reg <= yw;
                y_reg <= -xw;
                z_reg <= 20'(HALF_PI_Q16);
            end
            else if (xw < 0)
            begin
                x_reg <= -yw;
                y_reg <= xw;
                z_reg <= -20'(HALF_PI_Q16);
            end
            else
            begin
                x_reg <= xw;
                y_reg <= yw;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + cordic_atan(i_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - cordic_atan(i_reg);
            end
        end
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_reg;

endmodule

FILE: design/imuc_dp.sv
// Datapath: config registers, sample capture, shared multiplier, filter and
// angle state, result register. Depends on imuc_pkg, imuc_div, imuc_cordic.
module imuc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  imuc_pkg::cmd_t    cmd,
    output imuc_pkg::status_t status,
    input  imuc_pkg::sample_t sample,
    output imuc_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data
);
    import imuc_pkg::*;

    logic [47:0] gyro_bias_reg, accel_bias_reg, accel_range_reg;
    logic [47:0] mag_bias_reg, mag_range_reg, lowpass_gains_reg;
    logic [15:0] blend_gain_reg;
    logic [7:0]  mag_decim_reg;

    sample_t            sample_reg;
    result_t            result_reg;
    logic [7:0]         dec_count_reg;
    logic               get_mag_reg;
    logic signed [31:0] scaled_reg [9];
    logic signed [31:0] filt_reg [9];
    logic signed [31:0] rate_reg [2];
    logic signed [ANGLE_W-1:0] atan_reg [2];
    logic signed [31:0] roll_reg, pitch_reg;
    logic signed [51:0] prod_reg, acc_reg;
    logic [3:0]         div_job_reg;
    logic               cordic_job_reg;

    logic signed [16:0] gd [3], ad [3], md [3];
    logic signed [15:0] g_raw [3], a_raw [3], m_raw [3];
    logic signed [33:0] mul_a, gd34, base34;
    logic signed [17:0] mul_b;
    logic [15:0]        gain;
    logic signed [33:0] div_num;
    logic [15:0]        div_den;
    logic               div_done, cordic_done;
    logic signed [31:0] div_q;
    logic signed [ANGLE_W-1:0] cordic_z;
    logic signed [32:0] cor_y, cor_x;
    logic signed [63:0] lpf_val, blend_val;
    logic [16:0]        rate_mag [2];
    logic [16:0]        rate_quo [2];

    assign g_raw = '{sample_reg.gyro_x, sample_reg.gyro_y, sample_reg.gyro_z};
    assign a_raw = '{sample_reg.accel_x, sample_reg.accel_y, sample_reg.accel_z};
    assign m_raw = '{sample_reg.mag_x, sample_reg.mag_y, sample_reg.mag_z};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            gd[k] = 17'(g_raw[k]) - 17'($signed(gyro_bias_reg[16*k +: 16]));
            ad[k] = 17'(a_raw[k]) - 17'($signed(accel_bias_reg[16*k +: 16]));
            md[k] = 17'(m_raw[k]) - 17'($signed(mag_bias_reg[16*k +: 16]));
        end
    end

    // gyro rate over sample rate, truncated toward zero; |rate| < 2^17
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rate_mag[k] = scaled_reg[k][31] ? 17'(-scaled_reg[k]) : 17'(scaled_reg[k]);
            rate_quo[k] = 17'((37'(rate_mag[k]) * 37'(RATE_RECIP)) >> RATE_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_bias_reg     <= '0;
            accel_bias_reg    <= '0;
            accel_range_reg   <= 48'h000100010001;
            mag_bias_reg      <= '0;
            mag_range_reg     <= 48'h000100010001;
            lowpass_gains_reg <= 48'h800080008000;
            blend_gain_reg    <= 16'd32440;
            mag_decim_reg     <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GYRO_BIAS:     gyro_bias_reg     <= cfg_data;
                CFG_ACCEL_BIAS:    accel_bias_reg    <= cfg_data;
                CFG_ACCEL_RANGE:   accel_range_reg   <= cfg_data;
                CFG_MAG_BIAS:      mag_bias_reg      <= cfg_data;
                CFG_MAG_RANGE:     mag_range_reg     <= cfg_data;
                CFG_LOWPASS_GAINS: lowpass_gains_reg <= cfg_data;
                CFG_BLEND_GAIN:    blend_gain_reg    <= cfg_data[15:0];
                CFG_MAG_DECIM:     mag_decim_reg     <= cfg_data[7:0];
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        gd34   = 34'(gd[cmd.lane[1:0]]);
        base34 = (cmd.lane[0] ? 34'(pitch_reg) : 34'(roll_reg))
                 + 34'(rate_reg[cmd.lane[0]]);
        if (cmd.lane < 4'd3)
            gain = lowpass_gains_reg[15:0];
        else if (cmd.lane < 4'd6)
            gain = lowpass_gains_reg[31:16];
        else
            gain = lowpass_gains_reg[47:32];
        unique case (cmd.mul_sel)
            MUL_GYRO:
            begin
                mul_a = (cmd.lane == 4'd1) ? gd34 : -gd34;
                mul_b = 18'(GYRO_SCALE_Q16);
            end
            MUL_LPF:
            begin
                mul_a = 34'(scaled_reg[cmd.lane]) - 34'(filt_reg[cmd.lane]);
                mul_b = $signed({2'b00, gain});
            end
            MUL_BLEND_G:
            begin
                mul_a = base34;
                mul_b = $signed({2'b00, blend_gain_reg});
            end
            MUL_BLEND_A:
            begin
                mul_a = 34'(atan_reg[cmd.lane[0]]);
                mul_b = 18'(ONE_Q15) - $signed({2'b00, blend_gain_reg});
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.lane)
            DJ_ACC_X:      begin div_num = -(34'(ad[0]) <<< 16);
                                 div_den = accel_range_reg[15:0]; end
            DJ_ACC_Y:      begin div_num = 34'(ad[1]) <<< 16;
                                 div_den = accel_range_reg[31:16]; end
            DJ_ACC_Z:      begin div_num = -(34'(ad[2]) <<< 16);
                                 div_den = accel_range_reg[47:32]; end
            DJ_MAG_X:      begin div_num = -(34'(md[1]) <<< 16);
                                 div_den = mag_range_reg[31:16]; end
            DJ_MAG_Y:      begin div_num = 34'(md[0]) <<< 16;
                                 div_den = mag_range_reg[15:0]; end
            DJ_MAG_Z:      begin div_num = 34'(md[2]) <<< 16;
                                 div_den = mag_range_reg[47:32]; end
            default:       begin div_num = '0;
                                 div_den = '0; end
        endcase
        if (cmd.lane[0])
        begin
            cor_y = 33'(scaled_reg[3]);
            cor_x = -33'(scaled_reg[5]);
        end
        else
        begin
            cor_y = -33'(scaled_reg[4]);
            cor_x = -33'(scaled_reg[5]);
        end
    end

    imuc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    imuc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cordic_done),
        .angle (cordic_z)
    );

    assign lpf_val   = 64'(filt_reg[cmd.lane]) + r15(64'(prod_reg));
    assign blend_val = r15(64'(acc_reg) + 64'(prod_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_count_reg <= '0;
            get_mag_reg   <= 1'b0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            for (int k = 0; k < 9; k++)
                filt_reg[k] <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                get_mag_reg   <= (dec_count_reg == 8'd0);
                dec_count_reg <= ((dec_count_reg == 8'd0) ? mag_decim_reg : dec_count_reg)
                                 - 8'd1;
            end
            if (cmd.lpf_wb)
                filt_reg[cmd.lane] <= sat32(lpf_val);
            if (cmd.blend_wb)
            begin
                if (cmd.lane[0])
                    pitch_reg <= sat32(blend_val);
                else
                    roll_reg <= sat32(blend_val);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(mul_a * mul_b);
        for (int k = 0; k < 2; k++)
            rate_reg[k] <= scaled_reg[k][31] ? -$signed({15'd0, rate_quo[k]})
                                             : $signed({15'd0, rate_quo[k]});
        if (cmd.capture)
            sample_reg <= sample;
        if (cmd.gyro_wb)
            scaled_reg[cmd.lane] <= sat32(64'(prod_reg));
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        if (cmd.div_start)
            div_job_reg <= cmd.lane;
        if (div_done)
            scaled_reg[div_job_reg + 4'd3] <= div_q;
        if (cmd.cordic_start)
            cordic_job_reg <= cmd.lane[0];
        if (cordic_done)
            atan_reg[cordic_job_reg] <= cordic_z;
        if (cmd.out_load)
        begin
            result_reg.roll_angle   <= roll_reg;
            result_reg.pitch_angle  <= pitch_reg;
            result_reg.gyro_filt_x  <= filt_reg[0];
            result_reg.gyro_filt_y  <= filt_reg[1];
            result_reg.gyro_filt_z  <= filt_reg[2];
            result_reg.accel_filt_x <= filt_reg[3];
            result_reg.accel_filt_y <= filt_reg[4];
            result_reg.accel_filt_z <= filt_reg[5];
            result_reg.mag_filt_x   <= filt_reg[6];
            result_reg.mag_filt_y   <= filt_reg[7];
            result_reg.mag_filt_z   <= filt_reg[8];
            result_reg.mag_updated  <= get_mag_reg;
        end
    end

    assign result             = result_reg;
    assign status.div_done    = div_done;
    assign status.cordic_done = cordic_done;
    assign status.get_mag     = get_mag_reg;

endmodule

FILE: design/imuc_ctrl.sv
// Sequencer for one sample: gyro scale, divides, low-pass, atan2, blend.
// Depends on imuc_pkg; drives imuc_dp through cmd_t and reads status_t.
module imuc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  imuc_pkg::status_t status,
    output imuc_pkg::cmd_t    cmd
);
    import imuc_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] lane_reg, lane_next;
    logic       result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lane_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            if (cmd.out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        unique case (state_reg)
            S_IDLE:
                if (sample_valid)
                begin
                    state_next = S_GYRO_MUL;
                    lane_next  = '0;
                end
            S_GYRO_MUL:
                state_next = S_GYRO_WB;
            S_GYRO_WB:
                if (lane_reg == LANE_AXIS_LAST)
                begin
                    state_next = S_DIV_START;
                    lane_next  = DJ_ACC_X;
                end
                else
                begin
                    state_next = S_GYRO_MUL;
                    lane_next  = lane_reg + 4'd1;
                end
            S_DIV_START:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
                if (status.div_done)
                begin
                    priority if (lane_reg == DJ_MAG_Z
                                 || (lane_reg == DJ_ACC_Z && !status.get_mag))
                    begin
                        state_next = S_LPF_MUL;
                        lane_next  = '0;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                        lane_next  = lane_reg + 4'd1;
                    end
                end
            S_LPF_MUL:
                state_next = S_LPF_WB;
            S_LPF_WB:
                if (lane_reg == LPF_LAST || (lane_reg == LPF_ACCEL_LAST && !status.get_mag))
                begin
                    state_next = S_CORDIC_START;
                    lane_next  = '0;
                end
                else
                begin
                    state_next = S_LPF_MUL;
                    lane_next  = lane_reg + 4'd1;
                end
            S_CORDIC_START:
                state_next = S_CORDIC_WAIT;
            S_CORDIC_WAIT:
                if (status.cordic_done)
                begin
                    if (lane_reg == LANE_ANGLE_LAST)
                    begin
                        state_next = S_BLEND_G;
                        lane_next  = '0;
                    end
                    else
                    begin
                        state_next = S_CORDIC_START;
                        lane_next  = lane_reg + 4'd1;
                    end
                end
            S_BLEND_G:
                state_next = S_BLEND_A;
            S_BLEND_A:
                state_next = S_BLEND_WB;
            S_BLEND_WB:
                if (lane_reg == LANE_ANGLE_LAST)
                    state_next = S_FINISH;
                else
                begin
                    state_next = S_BLEND_G;
                    lane_next  = lane_reg + 4'd1;
                end
            S_FINISH:
                if (!result_valid_reg || result_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.lane     = lane_reg;
        cmd.mul_sel  = MUL_LPF;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.capture  = sample_valid;
            end
            S_GYRO_MUL:     cmd.mul_sel = MUL_GYRO;
            S_GYRO_WB:      cmd.gyro_wb = 1'b1;
            S_DIV_START:    cmd.div_start = 1'b1;
            S_LPF_WB:       cmd.lpf_wb = 1'b1;
            S_CORDIC_START: cmd.cordic_start = 1'b1;
            S_BLEND_G:      cmd.mul_sel = MUL_BLEND_G;
            S_BLEND_A:
            begin
                cmd.mul_sel  = MUL_BLEND_A;
                cmd.acc_load = 1'b1;
            end
            S_BLEND_WB:     cmd.blend_wb = 1'b1;
            S_FINISH:       cmd.out_load = !result_valid_reg || result_ready;
            default:        cmd.mul_sel = MUL_LPF;
        endcase
    end

    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait state");
    a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.cordic_done |-> state_reg == S_CORDIC_WAIT)
        else $error("cordic finished outside its wait state");
    a_mag_jobs_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_START && !status.get_mag) |-> lane_reg <= DJ_ACC_Z)
        else $error("magnetometer divide issued on a skipped sample");
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised without finishing a sample");
`endif

endmodule

FILE: design/imu_scale_lpf_complementary_unit.sv
// Top level of the IMU scale, low-pass and roll/pitch complementary filter.
// Depends on imuc_pkg, imuc_ctrl and imuc_dp.
//
//   channel   signals                              moves
//   sample    sample_valid sample_ready sample     one raw IMU request in
//   result    result_valid result_ready result     one filtered result out
//   cfg       cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One sample is processed at a time, with more work when the magnetometer is used;
// a new sample is accepted only after the previous one finishes. The bit-serial
// divider (six or three quotients) sets most of the processing time, and
// the 17-step CORDIC runs twice.
// Reset clears all filter state and loads default registers.
// A new sample is taken while the previous result waits in the output register;
// a stalled result holds the sequencer in its last state.
module imu_scale_lpf_complementary_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  imuc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output imuc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data
);
    import imuc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    imuc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    imuc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .result    (result),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for imu_scale_lpf_complementary_unit: a bit-exact predictor
// checks every result field against random and directed IMU requests and register sets.
// Depends on imuc_pkg and the RTL of the block only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imuc_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE     = 500;

    class imu_predictor;
        logic [47:0] gyro_bias, accel_bias, accel_range, mag_bias, mag_range, lp_gains;
        logic [15:0] blend;
        logic [7:0]  decim;
        int          roll_q, pitch_q;
        int          gyro_f[3], accel_f[3], mag_f[3];
        logic [7:0]  dec_cnt;
        result_t     expected_q[$];
        int          errors;

        function new();
            gyro_bias   = '0;
            accel_bias  = '0;
            mag_bias    = '0;
            accel_range = 48'h000100010001;
            mag_range   = 48'h000100010001;
            lp_gains    = 48'h800080008000;
            blend       = 16'd32440;
            decim       = 8'd10;
            roll_q      = 0;
            pitch_q     = 0;
            dec_cnt     = '0;
            errors      = 0;
            for (int i = 0; i < 3; i++)
            begin
                gyro_f[i]  = 0;
                accel_f[i] = 0;
                mag_f[i]   = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] d);
            case (idx)
                CFG_GYRO_BIAS:     gyro_bias   = d;
                CFG_ACCEL_BIAS:    accel_bias  = d;
                CFG_ACCEL_RANGE:   accel_range = d;
                CFG_MAG_BIAS:      mag_bias    = d;
                CFG_MAG_RANGE:     mag_range   = d;
                CFG_LOWPASS_GAINS: lp_gains    = d;
                CFG_BLEND_GAIN:    blend       = d[15:0];
                CFG_MAG_DECIM:     decim       = d[7:0];
                default: ;
            endcase
        endfunction

        function longint lane_s(logic [47:0] r, int i);
            logic signed [15:0] v;
            v = r[16*i +: 16];
            return longint'(v);
        endfunction

        function longint lane_u(logic [47:0] r, int i);
            return longint'({48'd0, r[16*i +: 16]});
        endfunction

        function int clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return int'(v);
        endfunction

        function longint round15(longint v);
            return (v + 16384) >>> 15;
        endfunction

        function int fixed_div(longint num, longint den);
            if (den == 0)
            begin
                if (num > 0)
                    return 32'sh7FFFFFFF;
                if (num < 0)
                    return 32'sh80000000;
                return 0;
            end
            return clip32((num * 65536) / den);
        endfunction

        function int smooth(int p, int s, longint g);
            longint d;
            d = longint'(s) - longint'(p);
            return clip32(longint'(p) + round15(d * g));
        endfunction

        function longint vec_angle(longint y_in, longint x_in);
            longint x, y, z, t, xs, ys;
            if (x_in == 0 && y_in == 0)
                return 0;
            x = x_in * 65536;
            y = y_in * 65536;
            z = 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q16;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q16;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += longint'(cordic_atan(5'(i)));
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= longint'(cordic_atan(5'(i)));
                end
            end
            return z;
        endfunction

        function void note_sample(sample_t s);
            longint  gd[3], ad[3], md[3];
            int      gs[3], acc_s[3], ms[3];
            longint  a, b, roll, pitch, ga, gb;
            bit      getmag;
            result_t r;
            getmag = 0;
            if (dec_cnt == 0)
            begin
                getmag  = 1;
                dec_cnt = decim;
            end
            dec_cnt = dec_cnt - 8'd1;
            gd[0] = longint'(s.gyro_x)  - lane_s(gyro_bias, 0);
            gd[1] = longint'(s.gyro_y)  - lane_s(gyro_bias, 1);
            gd[2] = longint'(s.gyro_z)  - lane_s(gyro_bias, 2);
            ad[0] = longint'(s.accel_x) - lane_s(accel_bias, 0);
            ad[1] = longint'(s.accel_y) - lane_s(accel_bias, 1);
            ad[2] = longint'(s.accel_z) - lane_s(accel_bias, 2);
            md[0] = longint'(s.mag_x)   - lane_s(mag_bias, 0);
            md[1] = longint'(s.mag_y)   - lane_s(mag_bias, 1);
            md[2] = longint'(s.mag_z)   - lane_s(mag_bias, 2);
            gs[0] = clip32(-gd[0] * GYRO_SCALE_Q16);
            gs[1] = clip32(gd[1] * GYRO_SCALE_Q16);
            gs[2] = clip32(-gd[2] * GYRO_SCALE_Q16);
            acc_s[0] = fixed_div(-ad[0], lane_u(accel_range, 0));
            acc_s[1] = fixed_div(ad[1], lane_u(accel_range, 1));
            acc_s[2] = fixed_div(-ad[2], lane_u(accel_range, 2));
            for (int i = 0; i < 3; i++)
            begin
                gyro_f[i]  = smooth(gyro_f[i], gs[i], lane_u(lp_gains, 0));
                accel_f[i] = smooth(accel_f[i], acc_s[i], lane_u(lp_gains, 1));
            end
            if (getmag)
            begin
                ms[0] = fixed_div(-md[1], lane_u(mag_range, 1));
                ms[1] = fixed_div(md[0], lane_u(mag_range, 0));
                ms[2] = fixed_div(md[2], lane_u(mag_range, 2));
                for (int i = 0; i < 3; i++)
                    mag_f[i] = smooth(mag_f[i], ms[i], lane_u(lp_gains, 2));
            end
            ga    = longint'({48'd0, blend});
            gb    = ONE_Q15 - ga;
            a     = vec_angle(-longint'(acc_s[1]), -longint'(acc_s[2]));
            b     = vec_angle(longint'(acc_s[0]), -longint'(acc_s[2]));
            roll  = longint'(roll_q) + longint'(gs[0]) / SAMPLE_RATE_HZ;
            pitch = longint'(pitch_q) + longint'(gs[1]) / SAMPLE_RATE_HZ;
            roll_q  = clip32(round15(ga * roll + gb * a));
            pitch_q = clip32(round15(ga * pitch + gb * b));
            r.roll_angle   = roll_q;
            r.pitch_angle  = pitch_q;
            r.gyro_filt_x  = gyro_f[0];
            r.gyro_filt_y  = gyro_f[1];
            r.gyro_filt_z  = gyro_f[2];
            r.accel_filt_x = accel_f[0];
            r.accel_filt_y = accel_f[1];
            r.accel_filt_z = accel_f[2];
            r.mag_filt_x   = mag_f[0];
            r.mag_filt_y   = mag_f[1];
            r.mag_filt_z   = mag_f[2];
            r.mag_updated  = getmag;
            expected_q.push_back(r);
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s expected %0d got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("roll_angle",   e.roll_angle,   got.roll_angle);
            cmp("pitch_angle",  e.pitch_angle,  got.pitch_angle);
            cmp("gyro_filt_x",  e.gyro_filt_x,  got.gyro_filt_x);
            cmp("gyro_filt_y",  e.gyro_filt_y,  got.gyro_filt_y);
            cmp("gyro_filt_z",  e.gyro_filt_z,  got.gyro_filt_z);
            cmp("accel_filt_x", e.accel_filt_x, got.accel_filt_x);
            cmp("accel_filt_y", e.accel_filt_y, got.accel_filt_y);
            cmp("accel_filt_z", e.accel_filt_z, got.accel_filt_z);
            cmp("mag_filt_x",   e.mag_filt_x,   got.mag_filt_x);
            cmp("mag_filt_y",   e.mag_filt_y,   got.mag_filt_y);
            cmp("mag_filt_z",   e.mag_filt_z,   got.mag_filt_z);
            cmp("mag_updated",  e.mag_updated,  got.mag_updated);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    sample_t     sample = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    imu_predictor imu_model = new();
    int           idle_cycles = 0;
    int           stall_mode = 0;
    int           stall_tick = 0;

    imu_scale_lpf_complementary_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // result side: check, stall pattern, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                imu_model.check_result(result);
            if ((result_valid && result_ready) || (sample_valid && sample_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("imu_scale_lpf_complementary_unit: mismatch");
                $finish;
            end
            if (stall_tick == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_tick <= $urandom_range(16, 200);
            end
            else
                stall_tick <= stall_tick - 1;
            case (stall_mode)
                0:       result_ready <= 1'b1;
                1:       result_ready <= $urandom_range(0, 1);
                default: result_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        imu_model.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // holds valid high after acceptance; caller lowers it for gaps
    task automatic send_sample(sample_t s);
        sample       <= s;
        sample_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sample_ready)
                break;
        end
        imu_model.note_sample(s);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (imu_model.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic sample_t mk(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                   logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                   logic [15:0] mx, logic [15:0] my, logic [15:0] mz);
        sample_t s;
        s.gyro_x  = gx;
        s.gyro_y  = gy;
        s.gyro_z  = gz;
        s.accel_x = ax;
        s.accel_y = ay;
        s.accel_z = az;
        s.mag_x   = mx;
        s.mag_y   = my;
        s.mag_z   = mz;
        return s;
    endfunction

    function automatic logic [15:0] rand_axis();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 512) - 256);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_lane(int kind);
        case ($urandom_range(0, 5))
            0:       return (kind == 1) ? 16'd0 : 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return (kind == 1) ? 16'($urandom_range(1, 4096))
                                        : 16'($urandom_range(20000, 32768));
        endcase
    endfunction

    task automatic random_regs();
        logic [15:0] bl;
        write_reg(CFG_GYRO_BIAS,
                  ($urandom_range(0, 1) != 0) ? 48'd0 : 48'({$urandom, $urandom}));
        write_reg(CFG_ACCEL_BIAS,
                  ($urandom_range(0, 1) != 0) ? 48'd0 : 48'({$urandom, $urandom}));
        write_reg(CFG_MAG_BIAS,
                  ($urandom_range(0, 1) != 0) ? 48'd0 : 48'({$urandom, $urandom}));
        write_reg(CFG_ACCEL_RANGE, {rand_lane(1), rand_lane(1), rand_lane(1)});
        write_reg(CFG_MAG_RANGE,   {rand_lane(1), rand_lane(1), rand_lane(1)});
        write_reg(CFG_LOWPASS_GAINS, {rand_lane(0), rand_lane(0), rand_lane(0)});
        case ($urandom_range(0, 3))
            0:       bl = 16'd0;
            1:       bl = 16'd32768;
            2:       bl = 16'($urandom);
            default: bl = 16'($urandom_range(30000, 32768));
        endcase
        write_reg(CFG_BLEND_GAIN, {32'($urandom), bl});
        write_reg(CFG_MAG_DECIM, {40'd0, 8'($urandom_range(0, 12))});
    endtask

    initial
    begin
        sample_t dir_q[$];
        int      burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: extremes, quadrants, all-zero accel
        dir_q = '{
            mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 16'h7FFF, 16'h7FFF),
            mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 16'h8000, 16'h8000),
            mk(100, -100, 5, 1, 1, 1, 3, -3, 7),
            mk(-7, 7, 0, -1, 1, -1, 0, 0, 0),
            mk(0, 0, 0, 1, -1, 1, 0, 0, 0),
            mk(0, 0, 0, -1, -1, -1, 0, 0, 0),
            mk(0, 0, 0, 0, 1, 0, 0, 0, 0),
            mk(0, 0, 0, 1, 0, 0, 0, 0, 0),
            mk(0, 0, 0, 0, 0, -1, 0, 0, 0),
            mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
               16'h5555, 16'hAAAA, 16'h5555),
            mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
               16'hAAAA, 16'h5555, 16'hAAAA)
        };
        foreach (dir_q[k])
            send_sample(dir_q[k]);
        drain();

        // zero divisors, gains above one, decimation of one
        write_reg(CFG_ACCEL_RANGE, 48'd0);
        write_reg(CFG_MAG_RANGE, 48'd0);
        write_reg(CFG_LOWPASS_GAINS, 48'hFFFFFFFFFFFF);
        write_reg(CFG_BLEND_GAIN, 48'hFFFF);
        write_reg(CFG_MAG_DECIM, 48'd1);
        send_sample(mk(1, 1, 1, 5, -5, 0, 5, -5, 0));
        send_sample(mk(-1, -1, -1, -5, 5, 9, -5, 5, 9));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_LOWPASS_GAINS, 48'd0);
        write_reg(CFG_BLEND_GAIN, 48'd0);
        write_reg(CFG_MAG_DECIM, 48'd0);
        write_reg(CFG_GYRO_BIAS, 48'h80007FFF8000);
        write_reg(CFG_ACCEL_BIAS, 48'h7FFF80007FFF);
        write_reg(CFG_MAG_BIAS, 48'hFFFFFFFFFFFF);
        send_sample(mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, 2, 3));
        send_sample(mk(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4, 5, 6));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            random_regs();
            burst = 0;
            for (int n = 0; n < 72; n++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    if ($urandom_range(0, 2) != 0)
                    begin
                        sample_valid <= 1'b0;
                        repeat ($urandom_range(1, 300)) @(posedge clk);
                    end
                end
                burst--;
                send_sample(mk(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                               rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                               rand_axis()));
            end
            drain();
        end

        if (imu_model.errors == 0)
            $display("imu_scale_lpf_complementary_unit: match");
        else
            $display("imu_scale_lpf_complementary_unit: mismatch");
        $finish;
    end
endmodule
